// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

// ----- sv/lfo_sh_pkg.sv -----
package lfo_sh_pkg;

  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_WIDTH_DEF      = 16;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned SEL_W   = 3;

  localparam logic [31:0] PHASE_INC_RESET = 32'd89478;
  localparam logic [31:0] RANDOM_SEED     = 32'h9E37_79B9;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PHASE_INC = 2'd0;

  // Fixed-point constants used to build the quarter-wave table.
  localparam bit [63:0] Q30_ONE     = 64'd1 << 30;
  localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Shift amounts of the xorshift32 generator.
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE   = 3'd0,
    WAVE_TRI    = 3'd1,
    WAVE_SAW    = 3'd2,
    WAVE_SQUARE = 3'd3,
    WAVE_HOLD   = 3'd4
  } wave_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    return x;
  endfunction

endpackage

// ----- sv/lfo_sh_if.sv -----
interface lfo_sh_in_if;
  logic                            valid;
  logic                            ready;
  logic [lfo_sh_pkg::SEL_W-1:0]    wave_select;

  modport source (output valid, output wave_select, input ready);
  modport sink   (input valid, input wave_select, output ready);
endinterface

interface lfo_sh_out_if #(
  parameter int unsigned VALUE_WIDTH = lfo_sh_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] lfo_value;

  modport source (output valid, output lfo_value, input ready);
  modport sink   (input valid, input lfo_value, output ready);
endinterface

// ----- sv/lfo_sh_front.sv -----
module lfo_sh_front #(
  parameter int unsigned VALUE_WIDTH = lfo_sh_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned ENTRY_W     = lfo_sh_pkg::SEL_W + lfo_sh_pkg::PHASE_W + VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lfo_sh_in_if.sink                    in_ch,
  input  logic [lfo_sh_pkg::PHASE_W-1:0] phase_inc,
  input  lfo_sh_pkg::q_status_t        q_stat,
  output logic                         push,
  output logic [ENTRY_W-1:0]           push_data
);
  import lfo_sh_pkg::*;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [31:0]            rnd_r, rnd_nxt;
  logic [VALUE_WIDTH-1:0] held_r, held_nxt;
  logic [PHASE_W:0]       sum;
  logic [31:0]            rnd_step;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  // Each beat carries the phase and held value as they stood before this tick.
  assign push_data   = {in_ch.wave_select, phase_r, held_r};

  assign sum      = {1'b0, phase_r} + {1'b0, phase_inc};
  assign rnd_step = xorshift32(rnd_r);

  always_comb begin
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    held_nxt  = held_r;
    if (push) begin
      phase_nxt = sum[PHASE_W-1:0];
      // A carry out of the accumulator is a phase wrap: draw a new held value.
      if (sum[PHASE_W]) begin
        rnd_nxt  = rnd_step;
        held_nxt = {~rnd_step[31], rnd_step[30:32-VALUE_WIDTH]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rnd_r   <= RANDOM_SEED;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- sv/lfo_sh_queue.sv -----
module lfo_sh_queue #(
  parameter int unsigned ENTRY_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [ENTRY_W-1:0]    push_data,
  input  logic                  pop,
  output logic [ENTRY_W-1:0]    pop_data,
  output lfo_sh_pkg::q_status_t q_stat
);
  import lfo_sh_pkg::*;

  logic [ENTRY_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/lfo_sh_back.sv -----
module lfo_sh_back #(
  parameter int unsigned SINE_TABLE_DEPTH = lfo_sh_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH      = lfo_sh_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned ENTRY_W          = lfo_sh_pkg::SEL_W + lfo_sh_pkg::PHASE_W + VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfo_sh_pkg::q_status_t q_stat,
  input  logic [ENTRY_W-1:0]    pop_data,
  output logic                  pop,
  lfo_sh_out_if.source          out_ch
);
  import lfo_sh_pkg::*;

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PW    = 31 + IDX_W;
  localparam bit [63:0]   FULL  = 64'd1 << (VALUE_WIDTH - 1);
  localparam bit [63:0]   MAXV  = FULL - 64'd1;

  // Quarter-wave table, built at elaboration from a truncating Q30 Taylor series.
  logic [VALUE_WIDTH-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam bit [63:0] X     = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
    localparam bit [63:0] X2    = (X * X) >> 30;
    localparam bit [63:0] T1    = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 156;
    localparam bit [63:0] T2    = Q30_ONE - ((X2 * T1) >> 30) / 110;
    localparam bit [63:0] T3    = Q30_ONE - ((X2 * T2) >> 30) / 72;
    localparam bit [63:0] T4    = Q30_ONE - ((X2 * T3) >> 30) / 42;
    localparam bit [63:0] T5    = Q30_ONE - ((X2 * T4) >> 30) / 20;
    localparam bit [63:0] T6    = Q30_ONE - ((X2 * T5) >> 30) / 6;
    localparam bit [63:0] S     = (X * T6) >> 30;
    localparam bit [63:0] V     = (S * FULL + (Q30_ONE >> 1)) >> 30;
    localparam bit [63:0] ENTRY = (V > MAXV) ? MAXV : V;
    assign sine_rom[k] = ENTRY[VALUE_WIDTH-1:0];
  end

  logic [SEL_W-1:0]       sel;
  logic [PHASE_W-1:0]     phase;
  logic [VALUE_WIDTH-1:0] held;
  logic [PW-1:0]          prod;
  logic [IDX_W-1:0]       idx, idx_q;
  logic [VALUE_WIDTH-1:0] rom_v, sine_v, tri_v, saw_v, sq_v, value;
  logic [PHASE_W-1:0]     tri_dist;
  logic [VALUE_WIDTH:0]   tri_sh;

  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r;

  assign {sel, phase, held} = pop_data;

  // Rounded table index within the quarter, mirrored in odd quadrants.
  assign prod   = PW'(phase[29:0]) * PW'(SINE_TABLE_DEPTH) + (PW'(1) << 29);
  assign idx    = prod[30 +: IDX_W];
  assign idx_q  = phase[30] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
  assign rom_v  = sine_rom[idx_q];
  assign sine_v = phase[31] ? -rom_v : rom_v;

  assign tri_dist = phase[31] ? (phase - 32'h8000_0000) : (32'h8000_0000 - phase);
  assign tri_sh   = tri_dist[31:31-VALUE_WIDTH];
  // Subtracting full scale flips the sign bit; the very top of the ramp saturates.
  assign tri_v  = tri_sh[VALUE_WIDTH] ? MAXV[VALUE_WIDTH-1:0]
                                      : {~tri_sh[VALUE_WIDTH-1], tri_sh[VALUE_WIDTH-2:0]};
  assign saw_v  = {~phase[31], phase[30:32-VALUE_WIDTH]};
  assign sq_v   = phase[31] ? FULL[VALUE_WIDTH-1:0] : MAXV[VALUE_WIDTH-1:0];

  always_comb begin
    unique case (sel)
      WAVE_TRI:    value = tri_v;
      WAVE_SAW:    value = saw_v;
      WAVE_SQUARE: value = sq_v;
      WAVE_HOLD:   value = held;
      default:     value = sine_v;
    endcase
  end

  assign pop           = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_value_r <= value;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.lfo_value = out_value_r;

endmodule

// ----- sv/multi_shape_lfo_with_sample_hold.sv -----
// Low-frequency oscillator with sine, triangle, saw, square and sample-and-hold
// shapes, all signed fixed point with VALUE_WIDTH bits. Each input beat is one
// sample tick: it yields one output beat with the selected shape's value at the
// current phase, after which the phase advances by the phase_increment register
// (byte address 0). On every phase wrap a xorshift32 generator draws a new held
// value. The block takes one beat per clock cycle while the queue is not full;
// a beat's result passes through the front-to-back queue into the output
// register, where it is held until taken. The two-entry queue lets input and
// output stall on their own, so up to three beats can be in flight. Write
// phase_increment only while no beats are in flight.
`include "assert_macros.svh"

module multi_shape_lfo_with_sample_hold #(
  parameter int unsigned SINE_TABLE_DEPTH = lfo_sh_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH      = lfo_sh_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lfo_sh_in_if.sink                          in_ch,
  lfo_sh_out_if.source                       out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lfo_sh_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lfo_sh_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lfo_sh_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import lfo_sh_pkg::*;

  localparam int unsigned ENTRY_W = SEL_W + PHASE_W + VALUE_WIDTH;

  logic [PHASE_W-1:0] inc_r, inc_nxt;
  logic               cfg_wr;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_data, pop_data;
  q_status_t          q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_PHASE_INC);
  assign cfg_prdata = (cfg_paddr == ADDR_PHASE_INC) ? inc_r : '0;
  assign inc_nxt    = cfg_wr ? cfg_pwdata : inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= PHASE_INC_RESET;
    end else begin
      inc_r <= inc_nxt;
    end
  end

  lfo_sh_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .phase_inc (inc_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lfo_sh_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  lfo_sh_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .VALUE_WIDTH      (VALUE_WIDTH),
    .ENTRY_W          (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // A queued beat moves to the output whenever the output register is free.
  `ASSERT_NEXT(a_queue_drains, !q_stat.empty && (!out_ch.valid || out_ch.ready), out_ch.valid, "queued beat did not reach the output")
  // With nothing queued, nothing arriving and the output free, no beat may appear.
  `ASSERT_NEXT(a_no_spurious_out, q_stat.empty && !(in_ch.valid && in_ch.ready) && (!out_ch.valid || out_ch.ready), !out_ch.valid, "output beat without a source")
  // The queue must never be written past its depth.
  `ASSERT_IMPLY(a_queue_bound, in_ch.valid && in_ch.ready, q_stat.count < QCNT_W'(QUEUE_DEPTH), "input accepted into a full queue")

endmodule

// ----- tb/tb_multi_shape_lfo_with_sample_hold.sv -----
module tb_multi_shape_lfo_with_sample_hold;
  timeunit 1ns;
  timeprecision 1ps;

  import lfo_sh_pkg::*;

  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam int unsigned SINE_DEPTH  = SINE_TABLE_DEPTH_DEF;
  localparam logic [63:0] Q30         = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_FX  = 64'd1686629713;
  localparam logic signed [VW-1:0] VAL_MAX = 16'h7FFF;
  localparam logic signed [VW-1:0] VAL_MIN = 16'h8000;
  localparam logic [SEL_W-1:0] SEL_SPARE0 = 3'd5;
  localparam logic [SEL_W-1:0] SEL_SPARE1 = 3'd6;
  localparam logic [SEL_W-1:0] SEL_SPARE2 = 3'd7;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 4;
  localparam int RAND_PHASES     = 9;
  localparam int MAX_PRINTS      = 30;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [31:0]             arg;
    logic                    typed;
    logic signed [VW-1:0]    want;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  // Increment 0 keeps the phase at 0, so every shape's value there is known outright.
  stim_row_t directed_rows [0:DIR_ROWS-1] = '{
    '{ROW_CFG,  32'h0000_0000,     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SINE),    1'b1, 16'sd0},
    '{ROW_TICK, 32'(WAVE_TRI),     1'b1, VAL_MAX},
    '{ROW_TICK, 32'(WAVE_SAW),     1'b1, VAL_MIN},
    '{ROW_TICK, 32'(WAVE_SQUARE),  1'b1, VAL_MAX},
    '{ROW_TICK, 32'(WAVE_HOLD),    1'b1, 16'sd0},
    '{ROW_TICK, 32'(SEL_SPARE0),   1'b1, 16'sd0},
    '{ROW_TICK, 32'(SEL_SPARE1),   1'b1, 16'sd0},
    '{ROW_TICK, 32'(SEL_SPARE2),   1'b1, 16'sd0},
    '{ROW_CFG,  32'h4000_0000,     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SINE),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SINE),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SQUARE),  1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_TRI),     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_HOLD),    1'b0, 16'sd0},
    '{ROW_CFG,  32'hFFFF_FFFF,     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SAW),     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_TRI),     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SINE),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_HOLD),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SQUARE),  1'b0, 16'sd0},
    '{ROW_CFG,  32'h8000_0000,     1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_HOLD),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_HOLD),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SINE),    1'b0, 16'sd0},
    '{ROW_TICK, 32'(WAVE_SQUARE),  1'b0, 16'sd0}
  };

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lfo_sh_in_if in_if ();
  lfo_sh_out_if #(.VALUE_WIDTH(VW)) out_if ();

  // Side band that travels with each input beat: a value typed into the table.
  logic tick_typed;
  logic signed [VW-1:0] tick_want;

  multi_shape_lfo_with_sample_hold u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Oscillator state mirrored on the bench.
  int          sine_q [0:SINE_DEPTH];
  logic [31:0] phase_now;
  logic [31:0] phase_step;
  logic [31:0] noise_state;
  logic signed [VW-1:0] held_now;

  logic signed [VW-1:0] pending_values [$];
  int  err_count;
  int  burst_left;
  bit  hold_req;

  task automatic flag_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void build_sine_quarter();
    logic [63:0] x, x2, t, s, r;
    int k, m;
    for (k = 0; k <= SINE_DEPTH; k++) begin
      x  = (HALF_PI_FX * k) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30;
      // Horner form of the Taylor series, highest term first.
      for (m = 6; m >= 1; m--) t = Q30 - ((x2 * t) >> 30) / (2 * m * (2 * m + 1));
      s = (x * t) >> 30;
      r = ((s << (VW - 1)) + (Q30 >> 1)) >> 30;
      if (r > 64'(VAL_MAX)) r = 64'(VAL_MAX);
      sine_q[k] = int'(r);
    end
  endfunction

  // Value of the selected shape at the current phase, then one phase step.
  function automatic logic signed [VW-1:0] lfo_tick(input logic [SEL_W-1:0] sel);
    logic [63:0] d, q, idx;
    logic signed [63:0] v;
    logic [32:0] sum;
    case (sel)
      WAVE_TRI: begin
        d = (phase_now >= 32'h8000_0000) ? phase_now - 32'h8000_0000
                                         : 32'h8000_0000 - phase_now;
        v = $signed((d << (VW - 1)) >> 30) - (64'sd1 <<< (VW - 1));
        if (v > 64'(VAL_MAX)) v = 64'(VAL_MAX);
      end
      WAVE_SAW: begin
        d = {32'd0, phase_now};
        v = $signed((d << (VW - 1)) >> 31) - (64'sd1 <<< (VW - 1));
      end
      WAVE_SQUARE: v = phase_now[31] ? 64'(VAL_MIN) : 64'(VAL_MAX);
      WAVE_HOLD:   v = 64'(held_now);
      default: begin
        q   = {34'd0, phase_now[29:0]};
        idx = (q * SINE_DEPTH + (Q30 >> 1)) >> 30;
        if (idx > SINE_DEPTH) idx = SINE_DEPTH;
        if (phase_now[30]) idx = SINE_DEPTH - idx;
        v = sine_q[idx];
        if (phase_now[31]) v = -v;
      end
    endcase
    sum = {1'b0, phase_now} + {1'b0, phase_step};
    if (sum[32]) begin
      noise_state = noise_state ^ (noise_state << XS_A);
      noise_state = noise_state ^ (noise_state >> XS_B);
      noise_state = noise_state ^ (noise_state << XS_C);
      // Top bits minus half scale is the top bits with the sign bit flipped.
      held_now = {~noise_state[31], noise_state[30:32-VW]};
    end
    phase_now = sum[31:0];
    return v[VW-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    logic signed [VW-1:0] got, exp_v, pred;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.lfo_value;
        if (pending_values.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat, lfo_value %0d", got));
        end else begin
          exp_v = pending_values.pop_front();
          if (got !== exp_v)
            flag_mismatch($sformatf("lfo_value %0d, expected %0d", got, exp_v));
        end
      end
      if (in_if.valid && in_if.ready) begin
        pred = lfo_tick(in_if.wave_select);
        pending_values.push_back(tick_typed ? tick_want : pred);
      end
    end
  end

  initial begin : receiver
    int stall_pct;
    int mode_left;
    stall_pct = 0;
    mode_left = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 4)) inside
          [0:1]: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      @(posedge clk);
    end
  end

  task automatic send_tick(input logic [SEL_W-1:0] sel, input logic typed,
                           input logic signed [VW-1:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid       <= 1'b1;
    in_if.wave_select <= sel;
    tick_typed        <= typed;
    tick_want         <= want;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write then read back, each as a setup beat followed by an access beat.
  task automatic write_phase_inc(input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_PHASE_INC;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    phase_step = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val)
      flag_mismatch($sformatf("phase_increment reads %h, wrote %h", cfg_prdata, val));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step(input int ph);
    case (ph)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return $urandom();
      3: return $urandom_range(32'h0100_0000, 32'h4000_0000);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      5: return $urandom_range(1, 1024);
      6: return PHASE_INC_RESET;
      7: return $urandom() | 32'h8000_0000;
      default: return $urandom_range(32'h1000_0000, 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_wave();
    if ($urandom_range(0, 9) < 3) return WAVE_HOLD;
    return SEL_W'($urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    int r, ph, i, n;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.wave_select <= WAVE_SINE;
    tick_typed        <= 1'b0;
    tick_want         <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= ADDR_PHASE_INC;
    cfg_pwdata        <= '0;
    err_count  = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    phase_now   = '0;
    phase_step  = PHASE_INC_RESET;
    noise_state = RANDOM_SEED;
    held_now    = '0;
    build_sine_quarter();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain_results();
        write_phase_inc(directed_rows[r].arg);
      end else begin
        send_tick(directed_rows[r].arg[SEL_W-1:0], directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      write_phase_inc(pick_step(ph));
      n = $urandom_range(50, 90);
      for (i = 0; i < n; i++) begin
        // Stall the output for a long stretch while input beats keep coming.
        if (ph == 4 && i == 10) hold_req = 1'b1;
        send_tick(pick_wave(), 1'b0, '0);
      end
    end

    drain_results();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
